[hw/rtl/lpht_pkg.sv]
// Shared types and constants for the linear-probing hash table.
// No dependencies; imported by lpht_ram users and the top level.
package lpht_pkg;

	// Table size; the home slot is taken from the low key bits, so keep it a power of two.
	localparam int TABLE_SLOTS  = 64;
	localparam int SLOT_W       = $clog2(TABLE_SLOTS);
	localparam int KEY_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int ENTRY_W      = STATUS_W + KEY_W;
	localparam int SLOT_FIELD_W = 6;

	typedef logic [1:0]              op_t;
	typedef logic [KEY_W-1:0]        key_t;
	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic [STATUS_W-1:0]     status_t;
	typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_SEARCH = 2'd2;

	localparam status_t ST_EMPTY   = 2'd0;
	localparam status_t ST_USED    = 2'd1;
	localparam status_t ST_DELETED = 2'd2;

endpackage

[hw/rtl/lpht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/linear_probe_hash_table.sv]
// Linear-probing hash table top level: probe sequencer, slot valid bits, result register.
// Depends on lpht_pkg and lpht_ram.
//
// Usage:
//   Input channel (in_valid / in_stall, req_type, item_key) carries one request per
//   beat: insert, delete or search. Output channel (out_valid / out_stall, success,
//   slot_index) returns exactly one result beat per request, in order.
//   in_stall is high while a request is in progress (probing or handing over its result);
//   one request is worked at a time. Each probe reads the slot RAM in S_READ (single read
//   port, registered data) and then compares and decides in S_CHECK. A request probes
//   from 1 up to TABLE_SLOTS slots before its result beat; a request with an unknown
//   operation code probes none and goes straight to its result.
//   The finished result sits in an output register; if the receiver stalls, the
//   sequencer holds the next result until the register frees, while a new request
//   can be accepted as soon as the previous result has been handed to that register.
//   Reset marks every slot empty at once through per-slot valid bits; no clearing
//   pass is needed, and requests are taken in the first cycle after reset.
module linear_probe_hash_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  lpht_pkg::op_t             req_type,
	input  lpht_pkg::key_t            item_key,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      success,
	output lpht_pkg::slot_field_t     slot_index
);
	import lpht_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	localparam slot_t LAST_PROBE = slot_t'(TABLE_SLOTS - 1);

	logic [1:0]             state_q;
	op_t                    op_q;
	key_t                   key_q;
	slot_t                  probe_q;
	slot_t                  count_q;
	logic                   res_ok_q;
	slot_t                  res_slot_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic                   out_valid_q;
	logic                   success_q;
	slot_field_t            slot_index_q;

	logic                   in_fire;
	logic                   out_free;
	logic [ENTRY_W-1:0]     rd_data;
	status_t                cur_status;
	key_t                   cur_key;
	logic                   key_hit;
	logic                   wr_en;
	logic [ENTRY_W-1:0]     wr_data;
	logic                   done;
	logic                   done_ok;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// A slot never written reads as empty.
	assign cur_status = valid_q[probe_q] ? rd_data[ENTRY_W-1:KEY_W] : ST_EMPTY;
	assign cur_key    = rd_data[KEY_W-1:0];
	assign key_hit    = (cur_status == ST_USED) && (cur_key == key_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = {ST_USED, key_q};
		done    = 1'b0;
		done_ok = 1'b0;
		if (state_q == S_CHECK) begin
			if (op_q == OP_INSERT) begin
				if (cur_status != ST_USED) begin
					wr_en   = 1'b1;
					done    = 1'b1;
					done_ok = 1'b1;
				end
			end else if (cur_status == ST_EMPTY) begin
				done = 1'b1;
			end else if (key_hit) begin
				done    = 1'b1;
				done_ok = 1'b1;
				// delete leaves a tombstone so later probes keep going
				if (op_q == OP_DELETE) begin
					wr_en   = 1'b1;
					wr_data = {ST_DELETED, cur_key};
				end
			end
			if (count_q == LAST_PROBE) begin
				done = 1'b1;
			end
		end
	end

	lpht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(probe_q),
		.wr_data(wr_data),
		.rd_en  (state_q == S_READ),
		.rd_addr(probe_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[probe_q] <= 1'b1;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (req_type inside {OP_INSERT, OP_DELETE, OP_SEARCH}) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= done ? S_FIN : S_READ;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request, probe position, pending and presented result.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q       <= req_type;
			key_q      <= item_key;
			probe_q    <= item_key[SLOT_W-1:0];
			count_q    <= '0;
			res_ok_q   <= 1'b0;
			res_slot_q <= '0;
		end
		if (state_q == S_CHECK) begin
			if (done) begin
				res_ok_q   <= done_ok;
				res_slot_q <= done_ok ? probe_q : '0;
			end else begin
				// advance with wrap at the table end
				probe_q <= (probe_q == LAST_PROBE) ? '0 : probe_q + slot_t'(1);
				count_q <= count_q + slot_t'(1);
			end
		end
		if (state_q == S_FIN && out_free) begin
			success_q    <= res_ok_q;
			slot_index_q <= slot_field_t'(res_slot_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign slot_index = slot_index_q;

endmodule
